@@ src/bounded_topk_heap_insert_macros.svh @@
`ifndef BOUNDED_TOPK_HEAP_INSERT_MACROS_SVH
`define BOUNDED_TOPK_HEAP_INSERT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while in reset
`define BTKH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset
`define BTKH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/btkh_pkg.sv @@
`default_nettype none

package btkh_pkg;

  // Fixed field widths
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned ID_W      = 24;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IDX_W     = CNT_W + 1;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd1;

  // One input item
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_key;
    logic [ID_W-1:0]     node_id;
  } btkh_in_t;

  // One result item
  typedef struct packed {
    logic [CNT_W-1:0]    entry_count;
    logic                is_full;
    logic [WEIGHT_W-1:0] min_weight;
    logic [ID_W-1:0]     min_id;
    logic                evicted_valid;
    logic [WEIGHT_W-1:0] evicted_weight;
    logic [ID_W-1:0]     evicted_id;
  } btkh_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVICT,
    S_CHILD,
    S_ROOT,
    S_SIFT_ADDR,
    S_SIFT_LEFT,
    S_SIFT_CMP,
    S_SORT_NEXT,
    S_SORT_LOAD,
    S_SORT_CMP,
    S_SORT_STEP,
    S_LEAST,
    S_DONE
  } btkh_state_e;

endpackage

`default_nettype wire

@@ src/btkh_out_stage.sv @@
`default_nettype none

module btkh_out_stage
  import btkh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  var  btkh_out_t item_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output btkh_out_t      out_item_o
);

  logic      valid_q;
  btkh_out_t item_q;

  // Free when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Held item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

@@ src/bounded_topk_heap_insert.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i  (btkh_in_t)
// out       output     out_valid_o / out_stall_i out_item_o (btkh_out_t)
// cfg       input      cfg_we_i                  cfg_data_i (capacity)
//
// Appending an item below capacity goes from accept straight to the result.
// The item that fills the store starts an insertion sort over the single
// store port: each element is read and compared, larger entries shift up.
// When full the old root is evicted and the root set (at capacity one the
// new entry just takes the slot), then it sifts down and the result loads.
// Reset clears count, capacity (to 1) and control; no clearing pass.
// A new item is taken while the last result still waits in the output
// register; a stalled output holds only the finished next result.
`default_nettype none

`include "bounded_topk_heap_insert_macros.svh"

module bounded_topk_heap_insert
  import btkh_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_BITS     = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  var  btkh_in_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output btkh_out_t             out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CNT_W-1:0] cfg_data_i
);

  localparam int unsigned KeyIdW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned EntW   = WEIGHT_W + KeyIdW;
  localparam int unsigned AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CapLim = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;

  btkh_state_e state_q, state_d;

  logic [CNT_W-1:0] cap_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] pi_q, pi_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic             ev_q, ev_d;
  logic [EntW-1:0]  nv_q, nv_d;
  logic [EntW-1:0]  cur_q, cur_d;
  logic [EntW-1:0]  l_q, l_d;
  logic [EntW-1:0]  least_q, least_d;
  logic [EntW-1:0]  evs_q, evs_d;
  logic [EntW-1:0]  rd_data_q;

  logic [EntW-1:0]  store_mem [MAX_ENTRIES];
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [EntW-1:0]  wr_data;

  logic             in_acc;
  logic [CNT_W-1:0] cap_eff;
  logic [EntW-1:0]  in_ent;
  logic             go_full, fills;
  logic             root_has_r, root_right, root_swap;
  logic [EntW-1:0]  root_small;
  logic [IDX_W-1:0] li_w, ri_w, cap_w;
  logic             sift_end, sift_has_r, l_sel, r_sel;
  logic [EntW-1:0]  l_min;
  logic             sort_done, sort_less, sort_at0;
  logic             out_ready, out_load;
  logic             is_full;
  btkh_out_t        res;

  // Effective capacity: zero acts as one, saturate at the store depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_q) > CapLim) begin
      cap_eff = CNT_W'(CapLim);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Entry keys compare as {weight, id} unsigned
  assign in_ent  = {in_item_i.weight_key, in_item_i.node_id[KeyIdW-1:0]};
  assign in_acc  = in_valid_i && !in_stall_o;
  assign go_full = cnt_q >= cap_eff;
  assign fills   = (cnt_q + CNT_W'(1)) == cap_eff;

  // Root step: right child wins a tie between the children
  assign root_has_r = cap_eff > CNT_W'(2);
  assign root_right = root_has_r && !(l_q < rd_data_q);
  assign root_small = root_right ? rd_data_q : l_q;
  assign root_swap  = root_small < nv_q;

  // Sift step: left child first, then right, both strict
  assign cap_w      = {1'b0, cap_eff};
  assign li_w       = {pi_q, 1'b1};
  assign ri_w       = li_w + IDX_W'(1);
  assign sift_end   = li_w >= cap_w;
  assign sift_has_r = ri_w < cap_w;
  assign l_sel      = l_q < cur_q;
  assign l_min      = l_sel ? l_q : cur_q;
  assign r_sel      = sift_has_r && (rd_data_q < l_min);

  // Insertion sort controls
  assign sort_done = idx_q >= cap_eff;
  assign sort_less = cur_q < rd_data_q;
  assign sort_at0  = j_q == '0;

  assign in_stall_o = state_q != S_IDLE;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (go_full) begin
            state_d = S_EVICT;
          end else if (fills) begin
            state_d = S_SORT_NEXT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_EVICT:     state_d = (cap_eff == CNT_W'(1)) ? S_DONE : S_CHILD;
      S_CHILD:     state_d = S_ROOT;
      S_ROOT:      state_d = S_SIFT_ADDR;
      S_SIFT_ADDR: state_d = sift_end ? S_DONE : S_SIFT_LEFT;
      S_SIFT_LEFT: state_d = S_SIFT_CMP;
      S_SIFT_CMP:  state_d = (l_sel || r_sel) ? S_SIFT_ADDR : S_DONE;
      S_SORT_NEXT: state_d = sort_done ? S_LEAST : S_SORT_LOAD;
      S_SORT_LOAD: state_d = S_SORT_CMP;
      S_SORT_CMP:  state_d = sort_less ? S_SORT_STEP : S_SORT_NEXT;
      S_SORT_STEP: state_d = sort_at0 ? S_SORT_NEXT : S_SORT_CMP;
      S_LEAST:     state_d = S_DONE;
      S_DONE:      state_d = out_ready ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath and store port controls
  always_comb begin
    cnt_d   = cnt_q;
    pi_d    = pi_q;
    idx_d   = idx_q;
    j_d     = j_q;
    ev_d    = ev_q;
    nv_d    = nv_q;
    cur_d   = cur_q;
    l_d     = l_q;
    least_d = least_q;
    evs_d   = evs_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = nv_q;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          nv_d = in_ent;
          ev_d = go_full;
          if (go_full) begin
            cnt_d = cap_eff;
            rd_en = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = AW'(cnt_q);
            wr_data = in_ent;
            cnt_d   = cnt_q + CNT_W'(1);
            idx_d   = CNT_W'(1);
          end
        end
      end
      // old root arrives; a single slot just takes the new entry
      S_EVICT: begin
        evs_d = rd_data_q;
        if (cap_eff == CNT_W'(1)) begin
          wr_en   = 1'b1;
          least_d = nv_q;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(1);
        end
      end
      S_CHILD: begin
        l_d = rd_data_q;
        if (root_has_r) begin
          rd_en   = 1'b1;
          rd_addr = AW'(2);
        end
      end
      // new root; sifting continues below the smaller child either way
      S_ROOT: begin
        wr_en = 1'b1;
        pi_d  = root_right ? CNT_W'(2) : CNT_W'(1);
        if (root_swap) begin
          wr_data = root_small;
          least_d = root_small;
          cur_d   = nv_q;
        end else begin
          least_d = nv_q;
          cur_d   = root_small;
        end
      end
      S_SIFT_ADDR: begin
        if (sift_end) begin
          wr_en   = 1'b1;
          wr_addr = AW'(pi_q);
          wr_data = cur_q;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(li_w);
        end
      end
      S_SIFT_LEFT: begin
        l_d = rd_data_q;
        if (sift_has_r) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ri_w);
        end
      end
      // move the smaller child up into the hole, or drop the entry here
      S_SIFT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pi_q);
        if (r_sel) begin
          wr_data = rd_data_q;
          pi_d    = CNT_W'(ri_w);
        end else if (l_sel) begin
          wr_data = l_q;
          pi_d    = CNT_W'(li_w);
        end else begin
          wr_data = cur_q;
        end
      end
      S_SORT_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = sort_done ? AW'(0) : AW'(idx_q);
      end
      S_SORT_LOAD: begin
        cur_d   = rd_data_q;
        j_d     = idx_q;
        rd_en   = 1'b1;
        rd_addr = AW'(idx_q - CNT_W'(1));
      end
      // shift the larger neighbor up, or place the held entry
      S_SORT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(j_q);
        if (sort_less) begin
          wr_data = rd_data_q;
          j_d     = j_q - CNT_W'(1);
        end else begin
          wr_data = cur_q;
          idx_d   = idx_q + CNT_W'(1);
        end
      end
      S_SORT_STEP: begin
        if (sort_at0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(0);
          wr_data = cur_q;
          idx_d   = idx_q + CNT_W'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(j_q - CNT_W'(1));
        end
      end
      S_LEAST: begin
        least_d = rd_data_q;
      end
      S_DONE: begin
        out_load = out_ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Result fields
  assign is_full = cnt_q == cap_eff;
  always_comb begin
    res = '0;
    res.entry_count   = cnt_q;
    res.is_full       = is_full;
    res.evicted_valid = ev_q;
    if (is_full) begin
      res.min_weight = least_q[EntW-1:KeyIdW];
      res.min_id     = ID_W'(least_q[KeyIdW-1:0]);
    end
    if (ev_q) begin
      res.evicted_weight = evs_q[EntW-1:KeyIdW];
      res.evicted_id     = ID_W'(evs_q[KeyIdW-1:0]);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CAP_RESET;
      cnt_q   <= '0;
      least_q <= '0;
      ev_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      least_q <= least_d;
      ev_q    <= ev_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pi_q  <= pi_d;
    idx_q <= idx_d;
    j_q   <= j_d;
    nv_q  <= nv_d;
    cur_q <= cur_d;
    l_q   <= l_d;
    evs_q <= evs_d;
  end

  // Entry store: one write or one registered read per cycle, never both
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  btkh_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .item_i      (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Checks
  `BTKH_ASSERT_IMP(a_port_exclusive, rd_en, !wr_en, "store read and write in one cycle")
  `BTKH_ASSERT_NXT(a_busy_after_accept, in_acc, state_q != S_IDLE, "idle after accept")
  `BTKH_ASSERT_NXT(a_append_count, in_acc && !go_full,
                   cnt_q == $past(cnt_q) + CNT_W'(1), "append count wrong")
  `BTKH_ASSERT_NXT(a_full_clamp, in_acc && go_full,
                   cnt_q == $past(cap_eff), "count not clamped to capacity")
  `BTKH_ASSERT_NXT(a_result_loaded, state_q == S_DONE && out_ready, out_valid_o,
                   "result not loaded")

endmodule

`default_nettype wire
